>>> sv/sfla_pkg.sv
package sfla_pkg;

  // default geometry
  localparam int unsigned DEF_HEAP_WORDS  = 16384;
  localparam int unsigned DEF_NUM_CLASSES = 29;

  // register and field widths
  localparam int unsigned CHUNK_W = 17;
  localparam int unsigned CLS_W   = 5;

  // heap constants
  localparam logic [CHUNK_W-1:0] DEF_CHUNK  = 17'd4096;
  localparam logic [31:0]        MIN_BLOCK  = 32'd16;
  localparam logic [31:0]        PROLOGUE   = 32'd9;
  localparam logic [31:0]        EPILOGUE   = 32'd1;
  localparam logic [31:0]        FIRST_BP   = 32'd16;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  // size field of a boundary tag
  function automatic logic [31:0] bsize(input logic [31:0] v);
    return {v[31:3], 3'b000};
  endfunction

  // size class: floor(log2 size) - 4, clamped to the class range
  function automatic logic [CLS_W-1:0] class_of(input logic [31:0] sz, input int unsigned nc);
    int unsigned m;
    int unsigned k;
    m = 0;
    for (int i = 0; i < 32; i++) begin
      if (sz[i]) m = i;
    end
    if (sz < MIN_BLOCK) k = 0;
    else k = m - 4;
    if (k > nc - 1) k = nc - 1;
    return CLS_W'(k);
  endfunction

endpackage

>>> sv/segregated_free_list_allocator_unit.sv
// Segregated free-list heap allocator with boundary tags over an internal
// single-port word memory of HEAP_WORDS 32-bit words. An input transaction
// carries the operation in tuser (0 allocate, 1 free), the request size in
// tdata[15:0] and the block address to free in tdata[31:16]; each one yields
// exactly one output transaction with the payload address and a status
// (0 ok, 1 zero-size request, 2 out of memory). Requests are handled one at
// a time by a sequencer driving the one memory port, one read or one write
// per cycle. How long an accepted free takes depends on how many neighbors
// it merges with. An allocation scans the class lists first-fit, class by
// class and node by node, then takes the chosen block whole or splits it;
// when nothing fits, it grows the heap before the block is taken. Every
// request also waits while the previous result has not been taken. After
// reset a formatting pass writes the initial heap image; no request is
// accepted during it, while configuration writes are taken at any time.
module segregated_free_list_allocator_unit #(
  parameter int unsigned HEAP_WORDS  = sfla_pkg::DEF_HEAP_WORDS,
  parameter int unsigned NUM_CLASSES = sfla_pkg::DEF_NUM_CLASSES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: extend_chunk_bytes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfla_pkg::CHUNK_W-1:0] cfg_data_i,
  // request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // request_size, block_address
  input  logic                         s_axis_tuser,  // operation
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata   // result_address, status, zero fill
);
  import sfla_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_WORDS);
  localparam int unsigned CW = $clog2(NUM_CLASSES);
  localparam int unsigned SW = $clog2(HEAP_WORDS) + 1;
  localparam logic [31:0] HB = 32'(HEAP_WORDS) * 32'd4;
  localparam bit FITS = (HB >= 32'd4112);
  localparam logic [CLS_W-1:0] INIT_CLS = class_of(32'd4096, NUM_CLASSES);

  // sequencer states
  localparam logic [5:0] S_CLEAR = 6'd0,  S_IDLE = 6'd1,   S_DONE = 6'd2,
                         S_FF_HEAD = 6'd3, S_FF_TEST = 6'd4, S_FF_CMP = 6'd5,
                         S_FF_NEXT = 6'd6, S_GROW = 6'd7, S_GROW_W2 = 6'd8,
                         S_GROW_W3 = 6'd9, S_AFTER_GROW = 6'd10, S_CARVE = 6'd11,
                         S_CV_RD = 6'd12, S_CV_CHK = 6'd13, S_CV_W2 = 6'd14,
                         S_CV_W3 = 6'd15, S_CV_W4 = 6'd16, S_CV_E2 = 6'd17,
                         S_FREE_RD = 6'd18, S_FREE_CHK = 6'd19, S_FREE_W2 = 6'd20,
                         S_M_RD = 6'd21, S_M_HDR = 6'd22, S_M_PRV = 6'd23,
                         S_M_PSZ = 6'd24, S_M_PA = 6'd25, S_M_NA = 6'd26,
                         S_MA_W1 = 6'd27, S_MA_W2 = 6'd28, S_MB_W1 = 6'd29,
                         S_MB_RD = 6'd30, S_MB_W2 = 6'd31, S_MC_SZ = 6'd32,
                         S_MC_UL2 = 6'd33, S_MC_W1 = 6'd34, S_MC_W2 = 6'd35,
                         S_L_RD = 6'd36, S_L_CLS = 6'd37, S_L_W2 = 6'd38,
                         S_L_W3 = 6'd39, S_U_RD = 6'd40, S_U_CLS = 6'd41,
                         S_U_P = 6'd42, S_U_S = 6'd43, S_U_W = 6'd44;

  logic [5:0]         state_q, state_d, ul_ret_q, ul_ret_d, mg_ret_q, mg_ret_d;
  logic [31:0]        bp_q, bp_d, size_q, size_d, prv_q, prv_d, nxt_q, nxt_d;
  logic [31:0]        psz_q, psz_d, nend_q, nend_d;
  logic [31:0]        ul_q, ul_d, ulp_q, ulp_d, uls_q, uls_d, lkh_q, lkh_d;
  logic [31:0]        cbp_q, cbp_d, asize_q, asize_d, cs_q, cs_d, p_q, p_d;
  logic [31:0]        brk_q, brk_d;
  logic [CLS_W-1:0]   ulc_q, ulc_d, lkc_q, lkc_d, cls_q, cls_d;
  logic               pa_q, pa_d;
  logic [SW-1:0]      steps_q, steps_d;
  logic [15:0]        res_q, res_d, req_a_q, req_a_d;
  logic [1:0]         st_q, st_d;
  logic               out_valid_q;
  logic [17:0]        out_data_q;
  logic [CHUNK_W-1:0] chunk_q;
  logic [AW-1:0]      clr_q;

  // memory port
  logic [31:0]   mem_q [HEAP_WORDS];
  logic [31:0]   mem_rd_q, rd;
  logic          rng_q;
  logic          mem_we;
  logic [31:0]   mem_addr, mem_wdata;
  logic          mem_in_rng;
  logic [AW-1:0] mem_idx;

  // class list heads
  logic [31:0]      heads_q [NUM_CLASSES];
  logic             heads_we;
  logic [CLS_W-1:0] heads_widx, hidx;
  logic [31:0]      heads_wdata, heads_rd;

  // shared temporaries
  logic [31:0] n32, gsize, ext, diff;
  logic        na;

  // initial heap image for one word
  function automatic logic [31:0] init_word(input logic [AW-1:0] w);
    logic [31:0] wi;
    wi = 32'(w);
    if (wi == 32'd1 || wi == 32'd2) return PROLOGUE;
    if (wi == 32'd3) return FITS ? 32'd4096 : EPILOGUE;
    if (FITS && wi == 32'd1026) return 32'd4096;
    if (FITS && wi == 32'd1027) return EPILOGUE;
    return 32'd0;
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};

  assign mem_in_rng = (mem_addr[31:2] < 30'(HEAP_WORDS));
  assign mem_idx    = mem_addr[AW+1:2];
  assign rd         = rng_q ? mem_rd_q : 32'd0;
  assign heads_rd   = heads_q[hidx[CW-1:0]];
  assign hidx       = (state_q == S_L_CLS) ? class_of(bsize(rd), NUM_CLASSES) : cls_q;

  // single-port word memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we && mem_in_rng) mem_q[mem_idx] <= mem_wdata;
    mem_rd_q <= mem_q[mem_idx];
    rng_q    <= mem_in_rng;
  end

  // sequencer next state and datapath
  always_comb begin
    state_d = state_q;   ul_ret_d = ul_ret_q; mg_ret_d = mg_ret_q;
    bp_d = bp_q;   size_d = size_q; prv_d = prv_q; nxt_d = nxt_q;
    psz_d = psz_q; nend_d = nend_q; ul_d = ul_q;   ulp_d = ulp_q;
    uls_d = uls_q; lkh_d = lkh_q;   cbp_d = cbp_q; asize_d = asize_q;
    cs_d = cs_q;   p_d = p_q;       brk_d = brk_q; ulc_d = ulc_q;
    lkc_d = lkc_q; cls_d = cls_q;   pa_d = pa_q;   steps_d = steps_q;
    res_d = res_q; st_d = st_q;     req_a_d = req_a_q;
    mem_we = 1'b0; mem_addr = 32'd0; mem_wdata = 32'd0;
    heads_we = 1'b0; heads_widx = '0; heads_wdata = 32'd0;
    n32   = {16'd0, s_axis_tdata[15:0]};
    ext   = (asize_q > 32'(chunk_q)) ? asize_q : 32'(chunk_q);
    gsize = {ext[31:3] + 29'(ext[2]), 3'b000};
    diff  = bsize(rd) - asize_q;
    na    = rd[0];
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = {{(30-AW){1'b0}}, clr_q, 2'b00};
        mem_wdata = init_word(clr_q);
        if (32'(clr_q) == 32'(HEAP_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          res_d = 16'd0;
          st_d  = ST_OK;
          req_a_d = s_axis_tdata[31:16];
          if (s_axis_tuser == OP_FREE) begin
            if (s_axis_tdata[18:16] == 3'b000 && s_axis_tdata[31:16] >= 16'd16 &&
                {16'd0, s_axis_tdata[31:16]} < brk_q) state_d = S_FREE_RD;
            else state_d = S_DONE;
          end else if (s_axis_tdata[15:0] == 16'd0) begin
            st_d    = ST_ZERO;
            state_d = S_DONE;
          end else begin
            asize_d = (n32 <= 32'd8) ? MIN_BLOCK : ((n32 + 32'd15) & ~32'd7);
            cls_d   = class_of((n32 <= 32'd8) ? MIN_BLOCK : ((n32 + 32'd15) & ~32'd7),
                               NUM_CLASSES);
            steps_d = '0;
            state_d = S_FF_HEAD;
          end
        end
      end
      // first-fit search over the class lists
      S_FF_HEAD: begin
        if (32'(cls_q) >= 32'(NUM_CLASSES)) state_d = S_GROW;
        else begin
          p_d     = heads_rd;
          state_d = S_FF_TEST;
        end
      end
      S_FF_TEST: begin
        if (p_q != 32'd0 && steps_q < SW'(HEAP_WORDS)) begin
          mem_addr = p_q - 32'd4;
          state_d  = S_FF_CMP;
        end else begin
          cls_d   = cls_q + CLS_W'(1);
          state_d = S_FF_HEAD;
        end
      end
      S_FF_CMP: begin
        if (asize_q <= bsize(rd)) begin
          cbp_d   = p_q;
          state_d = S_CARVE;
        end else begin
          mem_addr = p_q + 32'd4;
          state_d  = S_FF_NEXT;
        end
      end
      S_FF_NEXT: begin
        p_d     = rd;
        steps_d = steps_q + SW'(1);
        state_d = S_FF_TEST;
      end
      // heap extension
      S_GROW: begin
        if (brk_q > HB || gsize > HB - brk_q) begin
          st_d    = ST_OOM;
          state_d = S_DONE;
        end else begin
          bp_d      = brk_q;
          size_d    = gsize;
          brk_d     = brk_q + gsize;
          mem_we    = 1'b1;
          mem_addr  = brk_q - 32'd4;
          mem_wdata = gsize;
          state_d   = S_GROW_W2;
        end
      end
      S_GROW_W2: begin
        mem_we = 1'b1; mem_addr = bp_q + size_q - 32'd8; mem_wdata = size_q;
        state_d = S_GROW_W3;
      end
      S_GROW_W3: begin
        mem_we = 1'b1; mem_addr = bp_q + size_q - 32'd4; mem_wdata = EPILOGUE;
        mg_ret_d = S_AFTER_GROW;
        state_d  = S_M_RD;
      end
      S_AFTER_GROW: begin
        if (bp_q == 32'd0) begin
          st_d    = ST_OOM;
          state_d = S_DONE;
        end else begin
          cbp_d   = bp_q;
          state_d = S_CARVE;
        end
      end
      // carve the chosen block, splitting off the remainder when it is at least MIN_BLOCK bytes
      S_CARVE: begin
        res_d    = cbp_q[15:0];
        ul_d     = cbp_q;
        ul_ret_d = S_CV_RD;
        state_d  = S_U_RD;
      end
      S_CV_RD: begin
        mem_addr = cbp_q - 32'd4;
        state_d  = S_CV_CHK;
      end
      S_CV_CHK: begin
        cs_d   = bsize(rd);
        mem_we = 1'b1; mem_addr = cbp_q - 32'd4;
        if (bsize(rd) >= asize_q && diff >= MIN_BLOCK) begin
          mem_wdata = asize_q | 32'd1;
          state_d   = S_CV_W2;
        end else begin
          mem_wdata = bsize(rd) | 32'd1;
          state_d   = S_CV_E2;
        end
      end
      S_CV_W2: begin
        mem_we = 1'b1; mem_addr = cbp_q + asize_q - 32'd8; mem_wdata = asize_q | 32'd1;
        state_d = S_CV_W3;
      end
      S_CV_W3: begin
        mem_we = 1'b1; mem_addr = cbp_q + asize_q - 32'd4; mem_wdata = cs_q - asize_q;
        state_d = S_CV_W4;
      end
      S_CV_W4: begin
        mem_we = 1'b1; mem_addr = cbp_q + cs_q - 32'd8; mem_wdata = cs_q - asize_q;
        bp_d     = cbp_q + asize_q;
        mg_ret_d = S_DONE;
        state_d  = S_M_RD;
      end
      S_CV_E2: begin
        mem_we = 1'b1; mem_addr = cbp_q + cs_q - 32'd8; mem_wdata = cs_q | 32'd1;
        state_d = S_DONE;
      end
      // free
      S_FREE_RD: begin
        mem_addr = {16'd0, req_a_q} - 32'd4;
        state_d  = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (rd[0] && bsize(rd) >= MIN_BLOCK && bsize(rd) <= brk_q - {16'd0, req_a_q}) begin
          cs_d = bsize(rd);
          mem_we = 1'b1; mem_addr = {16'd0, req_a_q} - 32'd4; mem_wdata = bsize(rd);
          state_d = S_FREE_W2;
        end else state_d = S_DONE;
      end
      S_FREE_W2: begin
        mem_we = 1'b1; mem_addr = {16'd0, req_a_q} + cs_q - 32'd8; mem_wdata = cs_q;
        bp_d     = {16'd0, req_a_q};
        mg_ret_d = S_DONE;
        state_d  = S_M_RD;
      end
      // coalescing with the neighbors
      S_M_RD: begin
        mem_addr = bp_q - 32'd4;
        state_d  = S_M_HDR;
      end
      S_M_HDR: begin
        size_d   = bsize(rd);
        mem_addr = bp_q - 32'd8;
        state_d  = S_M_PRV;
      end
      S_M_PRV: begin
        prv_d    = bp_q - bsize(rd);
        nxt_d    = bp_q + size_q;
        mem_addr = bp_q - bsize(rd) - 32'd4;
        state_d  = S_M_PSZ;
      end
      S_M_PSZ: begin
        psz_d    = bsize(rd);
        mem_addr = prv_q + bsize(rd) - 32'd8;
        state_d  = S_M_PA;
      end
      S_M_PA: begin
        pa_d     = rd[0];
        mem_addr = nxt_q - 32'd4;
        state_d  = S_M_NA;
      end
      S_M_NA: begin
        priority if (pa_q && !na) begin
          size_d = size_q + bsize(rd);
          ul_d = nxt_q; ul_ret_d = S_MA_W1; state_d = S_U_RD;
        end else if (!pa_q && na) begin
          size_d = size_q + psz_q;
          ul_d = prv_q; ul_ret_d = S_MB_W1; state_d = S_U_RD;
        end else if (!pa_q && !na) begin
          nend_d   = nxt_q + bsize(rd) - 32'd8;
          mem_addr = nxt_q + bsize(rd) - 32'd8;
          state_d  = S_MC_SZ;
        end else state_d = S_L_RD;
      end
      S_MA_W1: begin
        mem_we = 1'b1; mem_addr = bp_q - 32'd4; mem_wdata = size_q;
        state_d = S_MA_W2;
      end
      S_MA_W2: begin
        mem_we = 1'b1; mem_addr = bp_q + size_q - 32'd8; mem_wdata = size_q;
        state_d = S_L_RD;
      end
      S_MB_W1: begin
        mem_we = 1'b1; mem_addr = prv_q - 32'd4; mem_wdata = size_q;
        state_d = S_MB_RD;
      end
      S_MB_RD: begin
        mem_addr = bp_q - 32'd4;
        state_d  = S_MB_W2;
      end
      S_MB_W2: begin
        mem_we = 1'b1; mem_addr = bp_q + bsize(rd) - 32'd8; mem_wdata = size_q;
        bp_d    = prv_q;
        state_d = S_L_RD;
      end
      S_MC_SZ: begin
        size_d = size_q + psz_q + bsize(rd);
        ul_d = nxt_q; ul_ret_d = S_MC_UL2; state_d = S_U_RD;
      end
      S_MC_UL2: begin
        ul_d = prv_q; ul_ret_d = S_MC_W1; state_d = S_U_RD;
      end
      S_MC_W1: begin
        mem_we = 1'b1; mem_addr = prv_q - 32'd4; mem_wdata = size_q;
        state_d = S_MC_W2;
      end
      S_MC_W2: begin
        mem_we = 1'b1; mem_addr = nend_q; mem_wdata = size_q;
        bp_d    = prv_q;
        state_d = S_L_RD;
      end
      // push onto the head of its class list
      S_L_RD: begin
        mem_addr = bp_q - 32'd4;
        state_d  = S_L_CLS;
      end
      S_L_CLS: begin
        lkc_d  = hidx;
        lkh_d  = heads_rd;
        mem_we = 1'b1; mem_addr = bp_q; mem_wdata = 32'd0;
        state_d = S_L_W2;
      end
      S_L_W2: begin
        mem_we = 1'b1; mem_addr = bp_q + 32'd4; mem_wdata = lkh_q;
        state_d = S_L_W3;
      end
      S_L_W3: begin
        mem_we = (lkh_q != 32'd0); mem_addr = lkh_q; mem_wdata = bp_q;
        heads_we = 1'b1; heads_widx = lkc_q; heads_wdata = bp_q;
        state_d = mg_ret_q;
      end
      // remove from its class list
      S_U_RD: begin
        mem_addr = ul_q - 32'd4;
        state_d  = S_U_CLS;
      end
      S_U_CLS: begin
        ulc_d    = class_of(bsize(rd), NUM_CLASSES);
        mem_addr = ul_q;
        state_d  = S_U_P;
      end
      S_U_P: begin
        ulp_d    = rd;
        mem_addr = ul_q + 32'd4;
        state_d  = S_U_S;
      end
      S_U_S: begin
        uls_d = rd;
        if (ulp_q == 32'd0) begin
          mem_we = (rd != 32'd0); mem_addr = rd; mem_wdata = 32'd0;
          heads_we = 1'b1; heads_widx = ulc_q; heads_wdata = rd;
          state_d = ul_ret_q;
        end else begin
          mem_we = 1'b1; mem_addr = ulp_q + 32'd4; mem_wdata = rd;
          state_d = S_U_W;
        end
      end
      S_U_W: begin
        mem_we = (uls_q != 32'd0); mem_addr = uls_q; mem_wdata = ulp_q;
        state_d = ul_ret_q;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      brk_q       <= FITS ? 32'd4112 : FIRST_BP;
      chunk_q     <= DEF_CHUNK;
      out_valid_q <= 1'b0;
      ul_ret_q    <= S_IDLE;
      mg_ret_q    <= S_IDLE;
      for (int i = 0; i < int'(NUM_CLASSES); i++) begin
        heads_q[i] <= (FITS && i == int'(INIT_CLS)) ? FIRST_BP : 32'd0;
      end
    end else begin
      state_q  <= state_d;
      ul_ret_q <= ul_ret_d;
      mg_ret_q <= mg_ret_d;
      brk_q    <= brk_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (cfg_valid_i) chunk_q <= cfg_data_i;
      if (heads_we) heads_q[heads_widx[CW-1:0]] <= heads_wdata;
      if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    bp_q <= bp_d;   size_q <= size_d; prv_q <= prv_d; nxt_q <= nxt_d;
    psz_q <= psz_d; nend_q <= nend_d; ul_q <= ul_d;   ulp_q <= ulp_d;
    uls_q <= uls_d; lkh_q <= lkh_d;   cbp_q <= cbp_d; asize_q <= asize_d;
    cs_q <= cs_d;   p_q <= p_d;       ulc_q <= ulc_d; lkc_q <= lkc_d;
    cls_q <= cls_d; pa_q <= pa_d;     steps_q <= steps_d;
    res_q <= res_d; st_q <= st_d;     req_a_q <= req_a_d;
    if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) out_data_q <= {st_q, res_q};
  end

  // the break stays aligned and inside the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q[2:0] == 3'b000 && brk_q <= HB)
    else $error("break out of range");

  // the break never moves back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CLEAR |=> brk_q >= $past(brk_q))
    else $error("break decreased");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // a result carries a defined status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[17:16] == ST_OK || m_axis_tdata[17:16] == ST_ZERO ||
                       m_axis_tdata[17:16] == ST_OOM))
    else $error("bad status");

endmodule

>>> bench/alloc_checker.sv
// watches the request, result and configuration channels of the allocator,
// keeps a shadow heap and compares every result transaction against it
module alloc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [16:0] cfg_data_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [31:0] req_data_i,
  input  logic        req_user_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [23:0] rsp_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfla_pkg::*;

  localparam int unsigned WORDS   = DEF_HEAP_WORDS;
  localparam int unsigned CLASSES = DEF_NUM_CLASSES;
  localparam logic [31:0] BYTES   = 32'(WORDS * 4);

  // shadow state of the heap
  logic [31:0] shadow_mem [WORDS];
  logic [31:0] list_head [CLASSES];
  logic [31:0] brk;
  logic [31:0] chunk_bytes;

  // results still owed by the block
  logic [15:0] want_addr_q [$];
  logic [1:0]  want_status_q [$];

  int unsigned fails = 0;
  int unsigned pending_n = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending_n;

  function automatic logic [31:0] mem_rd(logic [31:0] a);
    logic [31:0] w;
    w = a >> 2;
    return (w < WORDS) ? shadow_mem[w] : 32'd0;
  endfunction

  function automatic void mem_wr(logic [31:0] a, logic [31:0] v);
    logic [31:0] w;
    w = a >> 2;
    if (w < WORDS) shadow_mem[w] = v;
  endfunction

  function automatic logic [31:0] tag_size(logic [31:0] a);
    return mem_rd(a) & ~32'h7;
  endfunction

  function automatic logic [31:0] tag_alloc(logic [31:0] a);
    return mem_rd(a) & 32'h1;
  endfunction

  function automatic int unsigned size_class(logic [31:0] sz);
    int unsigned k;
    k = 0;
    if (sz < 16) return 0;
    while (sz >= 32 && k < CLASSES - 1) begin
      sz = sz >> 1;
      k++;
    end
    return k;
  endfunction

  function automatic void list_remove(logic [31:0] bp);
    int unsigned c;
    logic [31:0] p, s;
    c = size_class(tag_size(bp - 4));
    p = mem_rd(bp);
    s = mem_rd(bp + 4);
    if (p == 0) begin
      if (s != 0) mem_wr(s, 0);
      list_head[c] = s;
    end else begin
      mem_wr(p + 4, s);
      if (s != 0) mem_wr(s, p);
    end
  endfunction

  function automatic void list_push(logic [31:0] bp);
    int unsigned c;
    logic [31:0] h;
    c = size_class(tag_size(bp - 4));
    h = list_head[c];
    mem_wr(bp, 0);
    mem_wr(bp + 4, h);
    if (h != 0) mem_wr(h, bp);
    list_head[c] = bp;
  endfunction

  function automatic logic [31:0] coalesce(logic [31:0] bp);
    logic [31:0] size, prv, nxt, pa, na, nend;
    size = tag_size(bp - 4);
    prv  = bp - tag_size(bp - 8);
    nxt  = bp + size;
    pa   = tag_alloc(prv + tag_size(prv - 4) - 8);
    na   = tag_alloc(nxt - 4);
    if (pa != 0 && na == 0) begin
      size += tag_size(nxt - 4);
      list_remove(nxt);
      mem_wr(bp - 4, size);
      mem_wr(bp + size - 8, size);
    end else if (pa == 0 && na != 0) begin
      size += tag_size(prv - 4);
      list_remove(prv);
      mem_wr(prv - 4, size);
      mem_wr(bp + tag_size(bp - 4) - 8, size);
      bp = prv;
    end else if (pa == 0 && na == 0) begin
      nend = nxt + tag_size(nxt - 4) - 8;
      size += tag_size(prv - 4) + tag_size(nend);
      list_remove(nxt);
      list_remove(prv);
      mem_wr(prv - 4, size);
      mem_wr(nend, size);
      bp = prv;
    end
    list_push(bp);
    return bp;
  endfunction

  function automatic logic [31:0] heap_grow(logic [31:0] nbytes);
    logic [31:0] words, size, bp;
    words = nbytes >> 2;
    if (words[0]) words++;
    size = words * 4;
    if (brk > BYTES || size > BYTES - brk) return 0;
    bp = brk;
    brk = brk + size;
    mem_wr(bp - 4, size);
    mem_wr(bp + size - 8, size);
    mem_wr(bp + size - 4, 1);
    return coalesce(bp);
  endfunction

  function automatic logic [31:0] fit_search(logic [31:0] asize);
    int unsigned steps;
    logic [31:0] p;
    steps = 0;
    for (int unsigned c = size_class(asize); c < CLASSES; c++) begin
      p = list_head[c];
      while (p != 0 && steps < WORDS) begin
        if (asize <= tag_size(p - 4)) return p;
        p = mem_rd(p + 4);
        steps++;
      end
    end
    return 0;
  endfunction

  function automatic void place(logic [31:0] bp, logic [31:0] asize);
    logic [31:0] cs, r, rs, dummy;
    list_remove(bp);
    cs = tag_size(bp - 4);
    if (cs >= asize && cs - asize >= 16) begin
      r  = bp + asize;
      rs = cs - asize;
      mem_wr(bp - 4, asize | 1);
      mem_wr(bp + asize - 8, asize | 1);
      mem_wr(r - 4, rs);
      mem_wr(r + rs - 8, rs);
      dummy = coalesce(r);
    end else begin
      mem_wr(bp - 4, cs | 1);
      mem_wr(bp + cs - 8, cs | 1);
    end
  endfunction

  function automatic void format_heap();
    logic [31:0] dummy;
    foreach (shadow_mem[i]) shadow_mem[i] = 0;
    foreach (list_head[i]) list_head[i] = 0;
    chunk_bytes = 32'(DEF_CHUNK);
    mem_wr(4, 9);
    mem_wr(8, 9);
    mem_wr(12, 1);
    brk = 16;
    dummy = heap_grow(chunk_bytes);
  endfunction

  // apply one request to the shadow heap and queue its result
  function automatic void predict_request(logic op, logic [15:0] n, logic [15:0] a);
    logic [31:0] res, asize, bp, ext, h, sz, dummy;
    logic [1:0]  st;
    res = 0;
    st  = ST_OK;
    if (op == OP_ALLOC) begin
      if (n == 0) begin
        st = ST_ZERO;
      end else begin
        asize = (n <= 8) ? 32'd16 : 8 * ((32'(n) + 15) / 8);
        bp = fit_search(asize);
        if (bp == 0) begin
          ext = (asize > chunk_bytes) ? asize : chunk_bytes;
          bp = heap_grow(ext);
        end
        if (bp == 0) begin
          st = ST_OOM;
        end else begin
          place(bp, asize);
          res = bp;
        end
      end
    end else if (a[2:0] == 0 && a >= 16 && 32'(a) < brk) begin
      h  = mem_rd(32'(a) - 4);
      sz = h & ~32'h7;
      if (h[0] && sz >= 16 && sz <= brk - 32'(a)) begin
        mem_wr(32'(a) - 4, sz);
        mem_wr(32'(a) + sz - 8, sz);
        dummy = coalesce(32'(a));
      end
    end
    want_addr_q.push_back(res[15:0]);
    want_status_q.push_back(st);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch: %s got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  // track every transaction on the three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_heap();
      want_addr_q.delete();
      want_status_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) chunk_bytes = 32'(cfg_data_i);
      if (req_valid_i && req_ready_i)
        predict_request(req_user_i, req_data_i[15:0], req_data_i[31:16]);
      if (rsp_valid_i && rsp_ready_i) begin
        if (want_addr_q.size() == 0) begin
          report("unexpected result, address", rsp_data_i[15:0], 0);
        end else begin
          if (rsp_data_i[15:0] != want_addr_q[0])
            report("result address", rsp_data_i[15:0], want_addr_q[0]);
          if (rsp_data_i[17:16] != want_status_q[0])
            report("status", rsp_data_i[17:16], want_status_q[0]);
          void'(want_addr_q.pop_front());
          void'(want_status_q.pop_front());
        end
      end
    end
    pending_n = want_addr_q.size();
  end

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfla_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // request_size, block_address
  logic        s_axis_tuser = 1'b0;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // result_address, status, zero fill

  int unsigned fail_count;
  int unsigned pending;
  bit          busy_sink = 1'b1;
  int unsigned sink_hold = 0;

  // payload offsets handed out and not yet freed
  logic [15:0] live_blocks [$];

  always #2 clk_i = ~clk_i;

  segregated_free_list_allocator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  alloc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_user_i   (s_axis_tuser),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // result side backpressure, held for random stretches
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      m_axis_tready <= !busy_sink || $urandom_range(0, 2) != 0;
      sink_hold <= gap_len();
    end
    if (m_axis_tvalid && m_axis_tready && m_axis_tdata[17:16] == ST_OK &&
        m_axis_tdata[15:0] != 0)
      live_blocks.push_back(m_axis_tdata[15:0]);
  end

  task automatic send_request(logic op, logic [15:0] n, logic [15:0] a, bit idle);
    int unsigned g;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {a, n};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    g = idle ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_chunk(logic [16:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] take_live();
    int unsigned k;
    logic [15:0] a;
    k = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    return a;
  endfunction

  function automatic logic [15:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return 0;
    if (r < 70) return 16'($urandom_range(1, 256));
    if (r < 90) return 16'($urandom_range(257, 4096));
    return 16'($urandom_range(4097, 65535));
  endfunction

  task automatic random_phase(int unsigned count, bit idle);
    int unsigned r;
    logic [15:0] a;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40 && live_blocks.size() != 0) begin
        send_request(OP_FREE, 16'($urandom), take_live(), idle);
      end else if (r < 46) begin
        // stray frees: random or misaligned offsets
        a = 16'($urandom);
        if (live_blocks.size() != 0 && a[0]) a = live_blocks[0] + 16'($urandom_range(1, 7));
        send_request(OP_FREE, 16'($urandom), a, idle);
      end else begin
        send_request(OP_ALLOC, pick_size(), 16'($urandom), idle);
      end
    end
    drain();
  endtask

  // stimulus
  initial begin
    logic [16:0] chunk_set [6];
    logic [15:0] a0, a1, a2;
    chunk_set = '{17'd16, 17'd65536, 17'd4096, 17'd17, 17'd24, 17'd1000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: size corners, zero and oversized requests, stray frees
    send_request(OP_ALLOC, 16'd0, 16'd0, 1'b0);
    send_request(OP_ALLOC, 16'd1, 16'd0, 1'b0);
    send_request(OP_ALLOC, 16'd8, 16'd0, 1'b0);
    send_request(OP_ALLOC, 16'd9, 16'd0, 1'b0);
    send_request(OP_ALLOC, 16'd16, 16'd0, 1'b0);
    send_request(OP_ALLOC, 16'd65535, 16'd0, 1'b0);
    send_request(OP_ALLOC, 16'd4000, 16'd0, 1'b0);
    send_request(OP_FREE, 16'hFFFF, 16'd20, 1'b0);
    send_request(OP_FREE, 16'd0, 16'd0, 1'b0);
    send_request(OP_FREE, 16'd0, 16'd8, 1'b0);
    send_request(OP_FREE, 16'd0, 16'hFFF8, 1'b0);
    send_request(OP_FREE, 16'd0, 16'hFFFF, 1'b0);
    drain();
    // neighbors on both sides free, then a double free
    a0 = live_blocks[0];
    a1 = live_blocks[1];
    a2 = live_blocks[2];
    send_request(OP_FREE, 16'd0, a0, 1'b0);
    send_request(OP_FREE, 16'd0, a2, 1'b0);
    send_request(OP_FREE, 16'd0, a1, 1'b0);
    send_request(OP_FREE, 16'd0, a1, 1'b0);
    send_request(OP_FREE, 16'd0, a1 + 16'd8, 1'b0);
    drain();
    live_blocks = live_blocks[3:$];

    // random phases over several growth settings
    foreach (chunk_set[p]) begin
      write_chunk(p == 5 ? 17'($urandom_range(16, 65536)) : chunk_set[p]);
      busy_sink = (p != 2);
      random_phase(215, p != 2);
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** segregated_free_list_allocator_unit: PASSED **");
    end else begin
      $display("** segregated_free_list_allocator_unit: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("** segregated_free_list_allocator_unit: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
sv/sfla_pkg.sv
sv/segregated_free_list_allocator_unit.sv
bench/alloc_checker.sv
bench/testbench.sv
